FILE: sv/windowed_sram_bus_slave_assert.svh
// Assertion macros for the windowed SRAM bus slave.
`ifndef WINDOWED_SRAM_BUS_SLAVE_ASSERT_SVH
`define WINDOWED_SRAM_BUS_SLAVE_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define WSBS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define WSBS_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define WSBS_ASSERT(label, clk, rst_n, prop, msg)

`define WSBS_ASSERT_NEVER(label, clk, rst_n, cond, msg)

`endif

`endif

FILE: sv/wsbs_pkg.sv
// Shared types, codes and defaults of the windowed SRAM bus slave.
package wsbs_pkg;

    localparam int unsigned STORE_BYTES_DEF = 65536;
    localparam logic [31:0] STORE_BASE_DEF  = 32'h0000_0000;
    localparam logic [31:0] WINDOW_BASE_DEF = 32'h0000_0000;

    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_LATCH_ENABLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LATCH_BASE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LATCH_SIZE   = 2'd2;

    localparam logic [5:0] ACC_BITS_8  = 6'd8;
    localparam logic [5:0] ACC_BITS_16 = 6'd16;
    localparam logic [5:0] ACC_BITS_32 = 6'd32;

    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_ILLEGAL = 1'b1;

    localparam logic REQ_READ  = 1'b0;
    localparam logic REQ_WRITE = 1'b1;

    typedef struct packed {
        logic        req_type;
        logic [31:0] offset;
        logic [5:0]  access_bits;
        logic [31:0] write_data;
    } req_t;

    typedef struct packed {
        logic        status;
        logic [31:0] read_data;
        logic        to_latch;
        logic [31:0] latch_offset;
        logic [31:0] stored_writes;
        logic [31:0] dropped_writes;
    } rsp_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CHECK,
        ST_ISSUE,
        ST_COLLECT,
        ST_RESP
    } state_t;

endpackage

FILE: sv/wsbs_range.sv
// Shared range unit: offset of an address from a base and its bound check.
module wsbs_range (
    input  logic [31:0] addr,
    input  logic [31:0] base,
    input  logic [31:0] limit,
    output logic        hit,
    output logic [31:0] diff
);
    logic [32:0] delta;

    assign delta = {1'b0, addr} - {1'b0, base};
    assign diff  = delta[31:0];
    assign hit   = !delta[32] && (delta[31:0] < limit);

endmodule

FILE: sv/wsbs_mem.sv
// Single-port byte store with registered read data.
module wsbs_mem #(
    parameter int unsigned DEPTH = wsbs_pkg::STORE_BYTES_DEF,
    parameter int unsigned IDX_W = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [IDX_W-1:0] addr,
    input  logic [7:0]       wdata,
    output logic [7:0]       rdata
);
    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: sv/windowed_sram_bus_slave.sv
// Top level of the windowed SRAM bus slave: sequencer, counters and config registers.
// An illegal size or a latch hand-over goes from the check straight to done; a write
// issues one memory port access per byte, and a read issues and collects each byte in turn.
// A new transfer is taken in the cycle after done; the receiver cannot stall.
// After reset a clearing pass that writes zero to every byte of the store holds busy high.
module windowed_sram_bus_slave #(
    parameter int unsigned STORE_BYTES = wsbs_pkg::STORE_BYTES_DEF,
    parameter logic [31:0] STORE_BASE  = wsbs_pkg::STORE_BASE_DEF,
    parameter logic [31:0] WINDOW_BASE = wsbs_pkg::WINDOW_BASE_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  wsbs_pkg::req_t                     req,
    output logic                               done,
    output wsbs_pkg::rsp_t                     rsp,
    input  logic                               cfg_we,
    input  logic [wsbs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [31:0]                        cfg_wdata
);
    import wsbs_pkg::*;

    `include "windowed_sram_bus_slave_assert.svh"

    localparam int unsigned IDX_W = $clog2(STORE_BYTES);

    state_t state_reg, state_next;

    logic              latch_enable_reg;
    logic [31:0]       latch_base_reg;
    logic [31:0]       latch_size_reg;

    logic              is_write_reg, is_write_next;
    logic              illegal_reg, illegal_next;
    logic [1:0]        cnt_m1_reg, cnt_m1_next;
    logic [1:0]        byte_idx_reg, byte_idx_next;
    logic [31:0]       addr_reg, addr_next;
    logic [31:0]       wdata_reg, wdata_next;
    logic [31:0]       rdata_reg, rdata_next;
    logic              hit_reg, hit_next;
    logic              status_reg, status_next;
    logic              to_latch_reg, to_latch_next;
    logic [31:0]       loff_reg, loff_next;
    logic [31:0]       store_cnt_reg, store_cnt_next;
    logic [31:0]       hole_cnt_reg, hole_cnt_next;
    logic [IDX_W-1:0]  clr_idx_reg, clr_idx_next;

    logic              accept;
    logic              last_byte;
    logic              clr_last;
    logic [31:0]       range_base;
    logic [31:0]       range_limit;
    logic              range_hit;
    logic [31:0]       range_diff;
    logic              mem_we;
    logic [IDX_W-1:0]  mem_addr;
    logic [7:0]        mem_wdata;
    logic [7:0]        mem_rdata;
    logic              req_illegal;
    logic [1:0]        req_cnt_m1;
    logic [31:0]       req_wdata_aligned;

    wsbs_range u_range (
        .addr  (addr_reg),
        .base  (range_base),
        .limit (range_limit),
        .hit   (range_hit),
        .diff  (range_diff)
    );

    wsbs_mem #(
        .DEPTH (STORE_BYTES),
        .IDX_W (IDX_W)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    assign accept    = (state_reg == ST_IDLE) && start;
    assign last_byte = (byte_idx_reg == cnt_m1_reg);
    assign clr_last  = (clr_idx_reg == IDX_W'(STORE_BYTES - 1));

    always_comb
    begin
        req_illegal       = 1'b0;
        req_cnt_m1        = 2'd0;
        req_wdata_aligned = req.write_data;
        unique case (req.access_bits)
            ACC_BITS_8:
            begin
                req_wdata_aligned = {req.write_data[7:0], 24'h000000};
            end
            ACC_BITS_16:
            begin
                req_cnt_m1        = 2'd1;
                req_wdata_aligned = {req.write_data[15:0], 16'h0000};
            end
            ACC_BITS_32:
            begin
                req_cnt_m1 = 2'd3;
            end
            default:
            begin
                req_illegal = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (illegal_reg || (latch_enable_reg && range_hit))
                begin
                    state_next = ST_RESP;
                end
                else
                begin
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE:
            begin
                if (!is_write_reg)
                begin
                    state_next = ST_COLLECT;
                end
                else if (last_byte)
                begin
                    state_next = ST_RESP;
                end
            end
            ST_COLLECT:
            begin
                state_next = last_byte ? ST_RESP : ST_ISSUE;
            end
            ST_RESP:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        busy        = (state_reg != ST_IDLE);
        done        = (state_reg == ST_RESP);
        range_base  = STORE_BASE;
        range_limit = 32'(STORE_BYTES);
        mem_we      = 1'b0;
        mem_addr    = range_diff[IDX_W-1:0];
        mem_wdata   = wdata_reg[31:24];
        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_addr  = clr_idx_reg;
                mem_wdata = 8'h00;
            end
            ST_CHECK:
            begin
                range_base  = latch_base_reg;
                range_limit = latch_size_reg;
            end
            ST_ISSUE:
            begin
                mem_we = is_write_reg && range_hit;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        is_write_next  = is_write_reg;
        illegal_next   = illegal_reg;
        cnt_m1_next    = cnt_m1_reg;
        byte_idx_next  = byte_idx_reg;
        addr_next      = addr_reg;
        wdata_next     = wdata_reg;
        rdata_next     = rdata_reg;
        hit_next       = hit_reg;
        status_next    = status_reg;
        to_latch_next  = to_latch_reg;
        loff_next      = loff_reg;
        store_cnt_next = store_cnt_reg;
        hole_cnt_next  = hole_cnt_reg;
        clr_idx_next   = clr_idx_reg;

        if (state_reg == ST_CLEAR)
        begin
            clr_idx_next = clr_idx_reg + IDX_W'(1);
        end

        if (accept)
        begin
            is_write_next = (req.req_type == REQ_WRITE);
            illegal_next  = req_illegal;
            cnt_m1_next   = req_cnt_m1;
            byte_idx_next = 2'd0;
            addr_next     = WINDOW_BASE + req.offset;
            wdata_next    = req_wdata_aligned;
            rdata_next    = 32'h0;
            status_next   = req_illegal ? STATUS_ILLEGAL : STATUS_OK;
            to_latch_next = 1'b0;
            loff_next     = 32'h0;
        end

        if (state_reg == ST_CHECK && !illegal_reg && latch_enable_reg && range_hit)
        begin
            to_latch_next = 1'b1;
            loff_next     = range_diff;
        end

        if (state_reg == ST_ISSUE)
        begin
            hit_next  = range_hit;
            addr_next = addr_reg + 32'd1;
            if (is_write_reg)
            begin
                byte_idx_next = byte_idx_reg + 2'd1;
                wdata_next    = {wdata_reg[23:0], 8'h00};
                if (range_hit)
                begin
                    store_cnt_next = store_cnt_reg + 32'd1;
                end
                else
                begin
                    hole_cnt_next = hole_cnt_reg + 32'd1;
                end
            end
        end

        if (state_reg == ST_COLLECT)
        begin
            byte_idx_next = byte_idx_reg + 2'd1;
            rdata_next    = {rdata_reg[23:0], hit_reg ? mem_rdata : 8'h00};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            clr_idx_reg      <= '0;
            store_cnt_reg    <= 32'h0;
            hole_cnt_reg     <= 32'h0;
            latch_enable_reg <= 1'b0;
            latch_base_reg   <= 32'h0;
            latch_size_reg   <= 32'h0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_idx_reg   <= clr_idx_next;
            store_cnt_reg <= store_cnt_next;
            hole_cnt_reg  <= hole_cnt_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_LATCH_ENABLE: latch_enable_reg <= cfg_wdata[0];
                    CFG_LATCH_BASE:   latch_base_reg   <= cfg_wdata;
                    CFG_LATCH_SIZE:   latch_size_reg   <= cfg_wdata;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        is_write_reg <= is_write_next;
        illegal_reg  <= illegal_next;
        cnt_m1_reg   <= cnt_m1_next;
        byte_idx_reg <= byte_idx_next;
        addr_reg     <= addr_next;
        wdata_reg    <= wdata_next;
        rdata_reg    <= rdata_next;
        hit_reg      <= hit_next;
        status_reg   <= status_next;
        to_latch_reg <= to_latch_next;
        loff_reg     <= loff_next;
    end

    assign rsp.status         = status_reg;
    assign rsp.read_data      = rdata_reg;
    assign rsp.to_latch       = to_latch_reg;
    assign rsp.latch_offset   = loff_reg;
    assign rsp.stored_writes  = store_cnt_reg;
    assign rsp.dropped_writes = hole_cnt_reg;

    `WSBS_ASSERT(a_done_then_idle, clk, rst_n, done |=> !busy, "done not followed by idle")
    `WSBS_ASSERT(a_collect_after_read_issue, clk, rst_n,
        (state_reg == ST_COLLECT) |-> ($past(state_reg) == ST_ISSUE) && !is_write_reg,
        "collect without a preceding read issue")
    `WSBS_ASSERT(a_illegal_clean, clk, rst_n,
        (done && status_reg == STATUS_ILLEGAL) |-> !to_latch_reg && (rdata_reg == 32'h0),
        "illegal size result carries data or latch flag")
    `WSBS_ASSERT_NEVER(a_no_store_write_idle, clk, rst_n, !busy && mem_we,
        "byte store written while idle")
    `WSBS_ASSERT(a_latch_keeps_counters, clk, rst_n,
        (done && to_latch_reg) |-> $stable(store_cnt_reg) && $stable(hole_cnt_reg),
        "latch hand-over changed write counters")

endmodule
